[rtl/ecc_pkg.sv]
// Shared types, constants and helpers for the escape cook codec.
package ecc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_MODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LIM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_0    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_1    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_2    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_3    = 3'd6;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       MODE_ASCII = 1'b0;
    localparam logic [6:0] LIMIT_RESET = 7'd78;
    localparam logic [63:0] MASK0_RESET = 64'd1035087116799;
    localparam logic [63:0] MASK1_RESET = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MASK2_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK3_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] ESC_BASE    = 8'o044;
    localparam logic [7:0] CODE_OFFSET = 8'o050;
    localparam logic [7:0] CR_BYTE     = 8'o015;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic         direction;
        logic         line_mode;
        logic [6:0]   line_limit;
        logic [255:0] escape_mask;
    } t_cfg;

    // Results of one item: count of valid bytes (0..3) and the bytes in order.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } t_run;

    function automatic logic is_flagged(input logic [255:0] mask, input logic [7:0] b);
        return mask[b];
    endfunction

endpackage

[rtl/ecc_cfg.sv]
// Configuration registers of the escape cook codec.
module ecc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ecc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ecc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ecc_pkg::t_cfg                   o_cfg
);
    import ecc_pkg::*;

    logic         r_direction;
    logic         r_line_mode;
    logic [6:0]   r_line_limit;
    logic [255:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= DIR_ENCODE;
            r_line_mode  <= MODE_ASCII;
            r_line_limit <= LIMIT_RESET;
            r_mask       <= {MASK3_RESET, MASK2_RESET, MASK1_RESET, MASK0_RESET};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIRECTION: r_direction  <= i_cfg_data[0];
                CFG_LINE_MODE: r_line_mode  <= i_cfg_data[0];
                CFG_LINE_LIM:  r_line_limit <= i_cfg_data[6:0];
                CFG_MASK_0:    r_mask[63:0]    <= i_cfg_data;
                CFG_MASK_1:    r_mask[127:64]  <= i_cfg_data;
                CFG_MASK_2:    r_mask[191:128] <= i_cfg_data;
                CFG_MASK_3:    r_mask[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = '{direction:   r_direction,
                     line_mode:   r_line_mode,
                     line_limit:  r_line_limit,
                     escape_mask: r_mask};

endmodule

[rtl/ecc_core.sv]
// Input register, per-item encode/decode logic and codec state.
module ecc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecc_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ecc_pkg::t_in_item i_in_item,
    input  logic              i_buf_free,
    output logic              o_load,
    output ecc_pkg::t_run     o_run
);
    import ecc_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic [6:0] r_line_count;
    logic       r_pending;
    logic [1:0] r_group;

    logic [6:0] n_line_count;
    logic       n_pending;
    logic [1:0] n_group;

    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] look;
    logic       flag;
    logic [7:0] cnt;
    logic       ascii;
    logic       cr;
    t_run       run;

    assign o_load     = r_in_valid && i_buf_free;
    assign o_in_stall = r_in_valid && !i_buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (o_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_pending    <= 1'b0;
            r_group      <= '0;
        end else if (o_load) begin
            r_line_count <= n_line_count;
            r_pending    <= n_pending;
            r_group      <= n_group;
        end
    end

    always_comb begin
        b     = r_in.data_byte;
        ascii = (i_cfg.line_mode == MODE_ASCII);
        c     = ascii ? {1'b0, b[6:0]} : b;
        look  = (i_cfg.direction == DIR_ENCODE) ? b : c;
        flag  = is_flagged(i_cfg.escape_mask, look);
        cnt   = {1'b0, r_line_count} + (flag ? 8'd2 : 8'd1);
        // In ASCII line mode the end-of-block CR always fires, whatever the line count.
        cr    = ascii && ((cnt > {1'b0, i_cfg.line_limit}) || r_in.end_of_block);

        run          = '0;
        n_line_count = r_line_count;
        n_pending    = r_pending;
        n_group      = r_group;

        if (i_cfg.direction == DIR_ENCODE) begin
            if (flag) begin
                run.bytes[0] = ESC_BASE + {6'd0, b[7:6]};
                run.bytes[1] = {2'b00, b[5:0]} + CODE_OFFSET;
                run.bytes[2] = CR_BYTE;
                run.count    = cr ? 2'd3 : 2'd2;
            end else begin
                run.bytes[0] = b;
                run.bytes[1] = CR_BYTE;
                run.count    = cr ? 2'd2 : 2'd1;
            end
            if (ascii) begin
                n_line_count = cr ? 7'd0 : cnt[6:0];
            end
        end else begin
            if (r_pending) begin
                n_pending    = 1'b0;
                run.bytes[0] = (c - CODE_OFFSET) | {r_group, 6'd0};
                run.count    = 2'd1;
            end else if (!flag) begin
                run.bytes[0] = c;
                run.count    = 2'd1;
            end else if (c[7:2] == ESC_BASE[7:2]) begin
                // Start an escape; the next item completes it.
                n_pending = 1'b1;
                n_group   = c[1:0];
            end
        end
    end

    assign o_run = run;

`ifndef SYNTHESIS
    a_encode_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && i_cfg.direction == DIR_ENCODE) |-> (o_run.count != 2'd0))
        else $error("encode item produced no result");

    a_decode_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && i_cfg.direction != DIR_ENCODE) |-> (o_run.count == 2'd0 || o_run.count == 2'd1))
        else $error("decode item produced more than one result");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !i_buf_free) |=> r_in_valid)
        else $error("stalled input item lost");

    a_pending_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && r_pending && i_cfg.direction != DIR_ENCODE) |=> !r_pending)
        else $error("pending escape not consumed");
`endif

endmodule

[rtl/ecc_out.sv]
// Result buffer that hands out up to three bytes of one item, one per cycle while the output is not stalled.
module ecc_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ecc_pkg::t_run      i_run,
    output logic               o_buf_free,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ecc_pkg::t_out_item o_out_item
);
    import ecc_pkg::*;

    logic [1:0]      r_cnt;
    logic [1:0]      r_idx;
    logic [2:0][7:0] r_buf;

    logic       last;
    logic       take;
    logic [7:0] cur;

    assign o_out_valid = (r_cnt != 2'd0);
    assign last        = (r_idx == r_cnt - 2'd1);
    assign take        = o_out_valid && !i_out_stall;
    assign o_buf_free  = !o_out_valid || (take && last);

    always_comb begin
        case (r_idx)
            2'd0:    cur = r_buf[0];
            2'd1:    cur = r_buf[1];
            default: cur = r_buf[2];
        endcase
    end

    assign o_out_item = '{out_byte: cur, last_of_run: last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_run.count;
            r_idx <= '0;
        end else if (take) begin
            if (last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_run.bytes;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (r_idx < r_cnt))
        else $error("result index beyond count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_buf_free)
        else $error("result buffer overwritten");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !last && !i_load) |=> (r_idx == $past(r_idx) + 2'd1))
        else $error("result index did not advance");
`endif

endmodule

[rtl/escape_cook_codec.sv]
// Escape cook codec: byte-stuffing encoder and decoder for a serial link.
// Each item passes an input register and a single stage of encode or decode
// logic into a three-byte result buffer, which sends one byte per cycle while
// the output is not stalled. An item yields no byte or one, an escaped byte
// yields two, and an inserted carriage return adds one more; the buffer holds
// off the next item until these bytes are out. A new item is taken in the cycle
// the buffer hands out the last byte of the previous one. An accepted item
// passes the input register and then the result buffer before its first byte
// appears. Write configuration only while the codec is idle.
module escape_cook_codec (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ecc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ecc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ecc_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ecc_pkg::t_out_item              o_out_item
);
    import ecc_pkg::*;

    t_cfg cfg;
    t_run run;
    logic load;
    logic buf_free;

    ecc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ecc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_buf_free (buf_free),
        .o_load     (load),
        .o_run      (run)
    );

    ecc_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_run       (run),
        .o_buf_free  (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
